@@ hw/rtl/lzwd_pkg.sv @@
// lzwd_pkg: constants and transaction types for the lzw code decoder
// no dependencies
`default_nettype none
package lzwd_pkg;
   localparam int DICT_BITS   = 12;
   localparam int TABLE_DEPTH = 1 << DICT_BITS;
   localparam int CODE_W      = 12;
   localparam int FILL_W      = DICT_BITS + 1;

   localparam logic [FILL_W-1:0] FIRST_FREE  = FILL_W'(257);
   localparam logic [CODE_W-1:0] END_CODE    = CODE_W'(256);
   localparam logic [3:0]        START_WIDTH = 4'd9;
   localparam logic [3:0]        MAX_WIDTH   = 4'(DICT_BITS);

   localparam logic FUNC_DECODE = 1'b0;
   localparam logic FUNC_PULL   = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic              func;
      logic [CODE_W-1:0] code_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic        last_chunk;
      logic [3:0]  code_width;
      logic [31:0] total_bytes;
   } rsp_type;
endpackage
`default_nettype wire

@@ hw/rtl/lzw_code_decoder_top.sv @@
// lzw_code_decoder_top: lzw code decoder with table walk sequencer
// depends on lzwd_pkg and lzwd_ram
// decode: walks the chain to the head symbol, writes the pending symbol, pushes the string bytes, then adds an entry
// pull: fetches bytes from the stack one by one (up to 8), then gives the result
// one transaction at a time; the table ram read port sets the pace
// synchronous reset clears control state; table rams need no clearing
`default_nettype none
module lzw_code_decoder_top
   import lzwd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_H_READ, S_H_USE, S_SYM_WR, S_P_READ, S_P_USE,
      S_ADD, S_L_READ, S_L_USE, S_RESP
   } state_type;

   localparam int AW = DICT_BITS;

   state_type         state_ff;
   logic [CODE_W-1:0] code_ff, j_ff;
   logic [7:0]        head_ff;
   logic [FILL_W-1:0] n_ff, fill_ff, next_free_ff;
   logic [AW-1:0]     pending_ff;
   logic              pend_valid_ff;
   logic [3:0]        width_ff;
   logic [31:0]       total_ff;
   logic [1:0]        done_ff;
   logic [2:0]        k_ff;
   logic [63:0]       bytes_ff;
   rsp_type           rsp_ff;

   logic [CODE_W-1:0] par_rd;
   logic [7:0]        sym_rd, stk_rd, sym_now;
   logic [FILL_W-1:0] next_free_in;
   logic [FILL_W-1:0] fill_dec;

   assign next_free_in = next_free_ff + FILL_W'(1);
   assign fill_dec     = fill_ff - FILL_W'(1);
   assign sym_now = (j_ff < CODE_W'(256)) ? j_ff[7:0] : sym_rd;

   lzwd_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_parent (
      .clock(clock), .wr_en(state_ff == S_ADD && next_free_ff < FILL_W'(TABLE_DEPTH)),
      .wr_addr(next_free_ff[AW-1:0]), .wr_data(code_ff),
      .rd_addr(j_ff[AW-1:0]), .rd_data(par_rd));

   lzwd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_symbol (
      .clock(clock), .wr_en(state_ff == S_SYM_WR && pend_valid_ff),
      .wr_addr(pending_ff), .wr_data(head_ff),
      .rd_addr(j_ff[AW-1:0]), .rd_data(sym_rd));

   lzwd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_stack (
      .clock(clock), .wr_en(state_ff == S_P_USE),
      .wr_addr(n_ff[AW-1:0]), .wr_data(sym_now),
      .rd_addr(fill_dec[AW-1:0]), .rd_data(stk_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         next_free_ff  <= FIRST_FREE;
         width_ff      <= START_WIDTH;
         pend_valid_ff <= 1'b0;
         total_ff      <= '0;
         done_ff       <= ST_OK;
      end else begin
         case (state_ff)
            S_IDLE: begin
               rsp_ff.out_bytes  <= '0;
               rsp_ff.byte_count <= '0;
               rsp_ff.last_chunk <= 1'b0;
               rsp_ff.code_width <= width_ff;
               rsp_ff.total_bytes <= total_ff;
               code_ff  <= req_data.code_value;
               j_ff     <= req_data.code_value;
               head_ff  <= req_data.code_value[7:0];
               k_ff     <= '0;
               bytes_ff <= '0;
               if (req_valid) begin
                  if (req_data.func == FUNC_PULL) begin
                     if (fill_ff == '0) begin
                        rsp_ff.status <= ST_EMPTY;
                        state_ff      <= S_RESP;
                     end else begin
                        state_ff <= S_L_READ;
                     end
                  end else if (done_ff != ST_OK) begin
                     rsp_ff.status <= done_ff;
                     state_ff      <= S_RESP;
                  end else if (FILL_W'(req_data.code_value) >= next_free_ff) begin
                     done_ff       <= ST_ERROR;
                     rsp_ff.status <= ST_ERROR;
                     state_ff      <= S_RESP;
                  end else if (req_data.code_value == END_CODE) begin
                     done_ff       <= ST_END;
                     rsp_ff.status <= ST_END;
                     state_ff      <= S_RESP;
                  end else if (FILL_W'(req_data.code_value) < FIRST_FREE) begin
                     state_ff <= S_SYM_WR;
                  end else begin
                     state_ff <= S_H_READ;
                  end
               end
            end
            S_H_READ: state_ff <= S_H_USE;
            S_H_USE: begin
               j_ff    <= par_rd;
               head_ff <= par_rd[7:0];
               state_ff <= (FILL_W'(par_rd) < FIRST_FREE) ? S_SYM_WR : S_H_READ;
            end
            S_SYM_WR: begin
               j_ff     <= code_ff;
               n_ff     <= '0;
               state_ff <= S_P_READ;
            end
            S_P_READ: state_ff <= S_P_USE;
            S_P_USE: begin
               n_ff <= n_ff + FILL_W'(1);
               if (FILL_W'(j_ff) < FIRST_FREE) begin
                  state_ff <= S_ADD;
               end else begin
                  j_ff     <= par_rd;
                  state_ff <= S_P_READ;
               end
            end
            S_ADD: begin
               fill_ff  <= n_ff;
               total_ff <= total_ff + 32'(n_ff);
               rsp_ff.total_bytes <= total_ff + 32'(n_ff);
               rsp_ff.status <= ST_OK;
               if (next_free_ff < FILL_W'(TABLE_DEPTH)) begin
                  pending_ff    <= next_free_ff[AW-1:0];
                  pend_valid_ff <= 1'b1;
                  next_free_ff  <= next_free_in;
                  if (width_ff < MAX_WIDTH &&
                      {1'b0, next_free_in} > ((FILL_W+1)'(1) << width_ff)) begin
                     width_ff <= width_ff + 4'd1;
                     rsp_ff.code_width <= width_ff + 4'd1;
                  end
               end else begin
                  pend_valid_ff <= 1'b0;
               end
               state_ff <= S_RESP;
            end
            S_L_READ: begin
               fill_ff  <= fill_dec;
               state_ff <= S_L_USE;
            end
            S_L_USE: begin
               bytes_ff[k_ff*8 +: 8] <= stk_rd;
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd7 || fill_ff == '0) begin
                  rsp_ff.status     <= ST_OK;
                  rsp_ff.out_bytes  <= bytes_ff | (64'(stk_rd) << {k_ff, 3'b000});
                  rsp_ff.byte_count <= {1'b0, k_ff} + 4'd1;
                  rsp_ff.last_chunk <= (fill_ff == '0);
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_L_READ;
               end
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result waits");
   a_width: assert property (@(posedge clock) disable iff (reset)
      width_ff >= START_WIDTH && width_ff <= MAX_WIDTH) else $error("code width out of range");
   a_free: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FILL_W'(TABLE_DEPTH)) else $error("table overrun");
   a_pend: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> FILL_W'(pending_ff) < next_free_ff) else $error("pending entry beyond table");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_count <= 4'd8) else $error("chunk too long");
endmodule
`default_nettype wire

@@ hw/rtl/lzwd_ram.sv @@
// lzwd_ram: generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ bench/lzw_code_decoder_checker.sv @@
// lzw_code_decoder_checker: predicts each response of the lzw code decoder and compares it
// watches the request and response channels; depends on lzwd_pkg
`timescale 1ns / 100ps
module lzw_code_decoder_checker
   import lzwd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           outstanding,
   output int           decode_count,
   output int           pull_count,
   output int           data_count
);
   logic [FILL_W-1:0] parent_of [TABLE_DEPTH];
   logic [7:0]        tail_byte [TABLE_DEPTH];
   logic [7:0]        string_buf [TABLE_DEPTH];
   int                unpulled;
   int                free_entry;
   logic [3:0]        width_now;
   int                open_entry;
   bit                open_valid;
   logic [31:0]       produced;
   logic [1:0]        sticky;
   rsp_type           expected_rsp [$];

   function automatic rsp_type lzw_predict(req_type r);
      rsp_type e;
      int      j, n, steps, k;
      int      c;
      e = '0;
      c = int'(r.code_value);
      if (r.func == FUNC_DECODE) begin
         e.status = sticky;
         if (sticky != ST_OK) begin
         end else if (c >= free_entry) begin
            sticky = ST_ERROR;
            e.status = ST_ERROR;
         end else if (r.code_value == END_CODE) begin
            sticky = ST_END;
            e.status = ST_END;
         end else begin
            j = c;
            steps = 0;
            while (j >= int'(FIRST_FREE) && steps < TABLE_DEPTH) begin
               j = int'(parent_of[j]);
               steps++;
            end
            if (open_valid) tail_byte[open_entry] = j[7:0];
            n = 0;
            j = c;
            forever begin
               string_buf[n] = tail_byte[j];
               n++;
               if (j < int'(FIRST_FREE) || n >= TABLE_DEPTH) break;
               j = int'(parent_of[j]);
            end
            unpulled = n;
            produced = produced + 32'(n);
            if (free_entry < TABLE_DEPTH) begin
               parent_of[free_entry] = FILL_W'(c);
               open_entry = free_entry;
               open_valid = 1;
               free_entry++;
               if (width_now < MAX_WIDTH && free_entry > (1 << width_now))
                  width_now = width_now + 4'd1;
            end else begin
               open_valid = 0;
            end
         end
      end else if (unpulled == 0) begin
         e.status = ST_EMPTY;
      end else begin
         k = 0;
         while (k < 8 && unpulled > 0) begin
            unpulled--;
            e.out_bytes[8*k +: 8] = string_buf[unpulled];
            k++;
         end
         e.status = ST_OK;
         e.byte_count = 4'(k);
         e.last_chunk = (unpulled == 0);
      end
      e.code_width = width_now;
      e.total_bytes = produced;
      return e;
   endfunction

   assign outstanding = expected_rsp.size();

   initial begin
      fail_count = 0;
      decode_count = 0;
      pull_count = 0;
      data_count = 0;
      for (int i = 0; i < 256; i++) tail_byte[i] = 8'(i);
      unpulled = 0;
      free_entry = int'(FIRST_FREE);
      width_now = START_WIDTH;
      open_entry = 0;
      open_valid = 0;
      produced = '0;
      sticky = ST_OK;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && req_valid && !req_stall) begin
         if (req_data.func == FUNC_DECODE) decode_count++;
         else pull_count++;
         expected_rsp.push_back(lzw_predict(req_data));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("response transaction with nothing expected");
            fail_count++;
         end else begin
            e = expected_rsp.pop_front();
            if (e.byte_count != 0) data_count++;
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.out_bytes !== e.out_bytes) begin
               $error("out_bytes: expected %h, got %h", e.out_bytes, rsp_data.out_bytes);
               fail_count++;
            end
            if (rsp_data.byte_count !== e.byte_count) begin
               $error("byte_count: expected %0d, got %0d", e.byte_count,
                      rsp_data.byte_count);
               fail_count++;
            end
            if (rsp_data.last_chunk !== e.last_chunk) begin
               $error("last_chunk: expected %0d, got %0d", e.last_chunk,
                      rsp_data.last_chunk);
               fail_count++;
            end
            if (rsp_data.code_width !== e.code_width) begin
               $error("code_width: expected %0d, got %0d", e.code_width,
                      rsp_data.code_width);
               fail_count++;
            end
            if (rsp_data.total_bytes !== e.total_bytes) begin
               $error("total_bytes: expected %0d, got %0d", e.total_bytes,
                      rsp_data.total_bytes);
               fail_count++;
            end
         end
      end
   end
endmodule

@@ bench/lzw_code_decoder_top_tb.sv @@
// lzw_code_decoder_top_tb: drives code streams and pulls into the lzw code decoder
// depends on lzwd_pkg, lzw_code_decoder_top and lzw_code_decoder_checker
`timescale 1ns / 100ps
module lzw_code_decoder_top_tb;
   import lzwd_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count, outstanding, decode_count, pull_count, data_count;
   int rsp_seen;
   int idle_cycles;
   int next_code;
   bit stream_over;
   bit calm;

   lzw_code_decoder_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   lzw_code_decoder_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .outstanding(outstanding),
      .decode_count(decode_count), .pull_count(pull_count), .data_count(data_count)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) rsp_seen++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: one long hold-off early on, random stalls otherwise
   initial begin
      bit held;
      held = 0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= 60) begin
            held = 1;
            rsp_stall <= 1;
            repeat (3000) @(negedge clock);
         end else begin
            rsp_stall <= calm ? 1'b0 : (idle_gap() != 0);
         end
      end
   end

   task automatic send(logic f, logic [CODE_W-1:0] c);
      repeat (idle_gap()) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_data <= '{func: f, code_value: c};
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic decode(logic [CODE_W-1:0] c);
      send(FUNC_DECODE, c);
      if (!stream_over) begin
         if (c == END_CODE || int'(c) >= next_code) stream_over = 1;
         else if (next_code < TABLE_DEPTH) next_code++;
      end
   endtask

   task automatic pulls(int n);
      repeat (n) send(FUNC_PULL, '0);
   endtask

   function automatic logic [CODE_W-1:0] valid_code();
      int r, lo;
      r = $urandom_range(0, 99);
      lo = (next_code - 16 > int'(FIRST_FREE)) ? next_code - 16 : int'(FIRST_FREE);
      if (next_code == int'(FIRST_FREE) || r < 30) return CODE_W'($urandom_range(0, 255));
      if (r < 38) return CODE_W'(next_code - 1);
      if (r < 65) return CODE_W'($urandom_range(lo, next_code - 1));
      return CODE_W'($urandom_range(int'(FIRST_FREE), next_code - 1));
   endfunction

   initial begin
      req_valid = 0;
      req_data = '0;
      reset = 1;
      rsp_seen = 0;
      idle_cycles = 0;
      next_code = int'(FIRST_FREE);
      stream_over = 0;
      calm = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty pull, literal extremes, pending entry reuse, discarded string
      pulls(1);
      decode(0);
      pulls(1);
      decode(255);
      pulls(1);
      decode(CODE_W'(next_code - 1));
      pulls(2);
      decode(257);
      decode(CODE_W'(next_code - 1));
      decode(CODE_W'(next_code - 1));
      pulls(3);
      decode(128);
      pulls(2);

      // random well-formed stream with partial pulls and noise
      for (int i = 0; i < 1500; ) begin
         int np;
         if ((i / 300) % 2 == 1) calm = ($urandom_range(0, 3) == 0);
         else calm = 0;
         decode(valid_code());
         np = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 1);
         pulls(np);
         i += 1 + np;
      end
      calm = 0;

      // grow the table to full, then keep decoding with no entries added
      while (next_code < TABLE_DEPTH) begin
         decode(valid_code());
         if ($urandom_range(0, 19) == 0) pulls($urandom_range(1, 3));
      end
      repeat (20) begin
         decode(valid_code());
         pulls($urandom_range(0, 3));
      end
      decode(CODE_W'(TABLE_DEPTH - 1));
      pulls(1);

      // end marker with bytes still unpulled, then sticky end and draining
      decode(END_CODE);
      decode(CODE_W'(TABLE_DEPTH - 1));
      decode(0);
      pulls(4);

      @(negedge clock);
      req_valid <= 0;
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("run: %0d decode and %0d pull transactions, %0d chunks carried data",
               decode_count, pull_count, data_count);
      $display("run: table grown to full width, end marker and sticky end exercised");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
